FILE: rtl/fdl_pkg.sv
// Shared constants, types and register codes of the fractional delay line.
package fdl_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int MAX_DELAY   = 1023;
  localparam int ADDR_BITS   = 10;
  localparam int STORE_DEPTH = 1 << ADDR_BITS;
  localparam int FILL_BITS   = ADDR_BITS + 1;
  localparam int FRAC_BITS   = 8;
  localparam int DELAY_BITS  = ADDR_BITS + FRAC_BITS;
  localparam int WEIGHT_BITS = FRAC_BITS + 1;
  localparam int PROD_BITS   = SAMPLE_BITS + WEIGHT_BITS + 1;
  localparam int TERM_BITS   = PROD_BITS - FRAC_BITS;
  localparam int SUM_BITS    = TERM_BITS + 1;

  localparam int DELAY_LIMIT = (MAX_DELAY < STORE_DEPTH - 1) ? MAX_DELAY : STORE_DEPTH - 1;
  localparam logic [DELAY_BITS-1:0] DELAY_CAP    = DELAY_BITS'(DELAY_LIMIT << FRAC_BITS);
  localparam logic [DELAY_BITS-1:0] BYPASS_LIMIT = DELAY_BITS'(2 << FRAC_BITS);
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE  = WEIGHT_BITS'(1 << FRAC_BITS);

  localparam int OUT_DEPTH    = 4;
  localparam int OUT_PTR_BITS = 2;
  localparam int OUT_CNT_BITS = OUT_PTR_BITS + 1;

  localparam int DATA_BITS = 32;
  localparam int PADDR_BITS = 2;
  localparam logic [PADDR_BITS-1:0] ADDR_DELAY = PADDR_BITS'(0);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // Controls the shared multiplier of the interpolator.
  typedef struct packed {
    logic mul_b;   // multiply the older sample by the fraction
    logic mul_a;   // multiply the newer sample by one minus the fraction
    logic keep;    // the memory word was written since reset
    logic bypass;  // item skips interpolation
  } interp_ctrl_t;

endpackage

FILE: rtl/fdl_interp.sv
// Linear interpolator: one shared multiplier, product registers and a saturating sum.
module fdl_interp (
  input  logic                            clk,
  input  fdl_pkg::interp_ctrl_t           ctrl,
  input  fdl_pkg::sample_t                rd_sample,
  input  logic [fdl_pkg::FRAC_BITS-1:0]   frac,
  input  fdl_pkg::sample_t                bypass_sample,
  output fdl_pkg::sample_t                result
);
  import fdl_pkg::*;

  sample_t                       operand;
  logic [WEIGHT_BITS-1:0]        weight;
  logic signed [WEIGHT_BITS:0]   weight_s;
  logic signed [PROD_BITS-1:0]   product;
  logic signed [PROD_BITS-1:0]   prod;
  logic signed [PROD_BITS-1:0]   prod_b;
  logic signed [SUM_BITS-1:0]    sum;
  logic signed [SUM_BITS-1:0]    sat_hi;
  logic signed [SUM_BITS-1:0]    sat_lo;
  sample_t                       sat;

  // Words never written since reset read as zero.
  always_comb begin
    operand  = ctrl.keep ? rd_sample : '0;
    weight   = ctrl.mul_b ? {1'b0, frac} : WEIGHT_ONE - {1'b0, frac};
    weight_s = $signed({1'b0, weight});
    product  = PROD_BITS'(operand) * PROD_BITS'(weight_s);
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_b || ctrl.mul_a) begin
      prod <= product;
    end
    if (ctrl.mul_a) begin
      prod_b <= prod;
    end
  end

  // Each product is floored on its own, then the two are added and clamped.
  always_comb begin
    sat_hi = SUM_BITS'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
    sat_lo = -sat_hi - SUM_BITS'(1);
    sum    = SUM_BITS'($signed(prod[PROD_BITS-1:FRAC_BITS]))
           + SUM_BITS'($signed(prod_b[PROD_BITS-1:FRAC_BITS]));
    if (sum > sat_hi) begin
      sat = sat_hi[SAMPLE_BITS-1:0];
    end else if (sum < sat_lo) begin
      sat = sat_lo[SAMPLE_BITS-1:0];
    end else begin
      sat = sum[SAMPLE_BITS-1:0];
    end
    result = ctrl.bypass ? bypass_sample : sat;
  end

endmodule

FILE: rtl/fractional_delay_line.sv
// Top level of the fractional delay line: sample memory, sequencing, output queue, APB port.
//
//   channel   signals                              direction  payload
//   input     in_valid / in_ready                  in         sample_in (signed 24 bits)
//   output    out_valid / out_ready                out        sample_out (signed 24 bits)
//   config    psel penable pwrite paddr pwdata ... in/out     delay_q8 at byte address 0
//
// Input is refused while an item is in ph1; the single read port of the sample
// memory serves the two taps of an item in consecutive cycles, which sets this spacing.
// A result is written into the output queue in ph4, after its item has passed ph1, ph2 and ph3.
// Reset clears the write pointer, the fill count and all sequencing; the memory itself is
// not cleared, a fill count marks which slots hold written samples, so no clearing pass runs.
// A stalled output fills a four-entry queue; input is refused once four items are owed.
module fractional_delay_line (
  input  logic                              clk,
  input  logic                              rst,
  input  fdl_pkg::sample_t                  sample_in,
  input  logic                              in_valid,
  output logic                              in_ready,
  output fdl_pkg::sample_t                  sample_out,
  output logic                              out_valid,
  input  logic                              out_ready,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fdl_pkg::PADDR_BITS-1:0]    paddr,
  input  logic [fdl_pkg::DATA_BITS-1:0]     pwdata,
  output logic [fdl_pkg::DATA_BITS-1:0]     prdata,
  output logic                              pready
);
  import fdl_pkg::*;

  // Configuration register. The user must write it only while the block is idle; the block does not enforce this.
  logic [DELAY_BITS-1:0] delay_q8;

  assign pready = 1'b1;
  assign prdata = DATA_BITS'(delay_q8);

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_q8 <= '0;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_DELAY) begin
      delay_q8 <= pwdata[DELAY_BITS-1:0];
    end
  end

  // Tap decode. The delay is clamped to 1023 samples, one less than the memory depth; a delay
  // of two or less bypasses the memory entirely. Tap b lies ip places back, tap a one place newer.
  logic [DELAY_BITS-1:0] delay_eff;
  logic                  bypass_in;
  logic [ADDR_BITS-1:0]  ip;
  logic [FRAC_BITS-1:0]  frac_in;
  logic [ADDR_BITS-1:0]  addr_a_in;
  logic [ADDR_BITS-1:0]  addr_b_in;
  logic                  ok_a_in;
  logic                  ok_b_in;
  logic [ADDR_BITS-1:0]  ptr;
  logic [FILL_BITS-1:0]  fill;

  always_comb begin
    delay_eff = (delay_q8 > DELAY_CAP) ? DELAY_CAP : delay_q8;
    bypass_in = delay_eff <= BYPASS_LIMIT;
    ip        = delay_eff[DELAY_BITS-1:FRAC_BITS];
    frac_in   = delay_eff[FRAC_BITS-1:0];
    addr_b_in = ptr - ip;
    addr_a_in = ptr - ip + ADDR_BITS'(1);
    // A slot k places back holds a written sample only when k is below the fill count.
    ok_b_in   = {1'b0, ip} < fill;
    ok_a_in   = {1'b0, ip} <= fill;
  end

  // Item sequencing. ph1: read tap b. ph2: multiply b, read tap a, write the new sample.
  // ph3: multiply a. ph4: sum and saturate into the output queue.
  logic accept;
  logic out_xfer;
  logic ph1, ph2, ph3, ph4;
  logic [OUT_CNT_BITS-1:0] pending;

  assign accept   = in_valid && in_ready;
  assign in_ready = !ph1 && (pending != OUT_CNT_BITS'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      ph1 <= 1'b0;
      ph2 <= 1'b0;
      ph3 <= 1'b0;
      ph4 <= 1'b0;
    end else begin
      ph1 <= accept;
      ph2 <= ph1;
      ph3 <= ph2;
      ph4 <= ph3;
    end
  end

  // Pointer and fill count move at a non-bypass transfer, so the next item already sees them.
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr  <= '0;
      fill <= '0;
    end else if (accept && !bypass_in) begin
      ptr <= ptr + ADDR_BITS'(1);
      if (fill != FILL_BITS'(STORE_DEPTH)) begin
        fill <= fill + FILL_BITS'(1);
      end
    end
  end

  // Per-stage payload.
  sample_t               s1_x;
  logic                  s1_bypass;
  logic [FRAC_BITS-1:0]  s1_frac;
  logic [ADDR_BITS-1:0]  s1_addr_a;
  logic [ADDR_BITS-1:0]  s1_addr_b;
  logic [ADDR_BITS-1:0]  s1_waddr;
  logic                  s1_ok_a;
  logic                  s1_ok_b;
  sample_t               s3_x;
  logic                  s3_bypass;
  logic [FRAC_BITS-1:0]  s3_frac;
  logic                  s3_ok_a;
  sample_t               s4_x;
  logic                  s4_bypass;

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x      <= sample_in;
      s1_bypass <= bypass_in;
      s1_frac   <= frac_in;
      s1_addr_a <= addr_a_in;
      s1_addr_b <= addr_b_in;
      s1_waddr  <= ptr + ADDR_BITS'(1);
      s1_ok_a   <= ok_a_in;
      s1_ok_b   <= ok_b_in;
    end
    if (ph2) begin
      s3_x      <= s1_x;
      s3_bypass <= s1_bypass;
      s3_frac   <= s1_frac;
      s3_ok_a   <= s1_ok_a;
    end
    if (ph3) begin
      s4_x      <= s3_x;
      s4_bypass <= s3_bypass;
    end
  end

  // Sample memory: one read port, one write port. Tap b is read before the write of the
  // same item, since at the largest delay it is the slot that write replaces. Later items
  // only read at least one place back, so a written sample is always settled before use.
  sample_t              store [STORE_DEPTH];
  sample_t              rdata;
  logic [ADDR_BITS-1:0] raddr;
  logic                 mem_we;

  assign raddr  = ph1 ? s1_addr_b : s1_addr_a;
  assign mem_we = ph2 && !s1_bypass;

  always_ff @(posedge clk) begin
    rdata <= store[raddr];
    if (mem_we) begin
      store[s1_waddr] <= s1_x;
    end
  end

  // Interpolation.
  interp_ctrl_t          ictrl;
  logic [FRAC_BITS-1:0]  ifrac;
  sample_t               result;

  always_comb begin
    ictrl.mul_b  = ph2;
    ictrl.mul_a  = ph3;
    ictrl.keep   = ph2 ? s1_ok_b : s3_ok_a;
    ictrl.bypass = s4_bypass;
    ifrac        = ph2 ? s1_frac : s3_frac;
  end

  fdl_interp u_interp (
    .clk           (clk),
    .ctrl          (ictrl),
    .rd_sample     (rdata),
    .frac          (ifrac),
    .bypass_sample (s4_x),
    .result        (result)
  );

  // Output queue. The pending count covers items in flight and queued, so a result never
  // finds the queue full.
  sample_t                 outq [OUT_DEPTH];
  logic [OUT_PTR_BITS-1:0] wr_ptr;
  logic [OUT_PTR_BITS-1:0] rd_ptr;
  logic [OUT_CNT_BITS-1:0] queued;

  assign out_valid  = queued != '0;
  assign out_xfer   = out_valid && out_ready;
  assign sample_out = outq[rd_ptr];

  always_ff @(posedge clk) begin
    if (ph4) begin
      outq[wr_ptr] <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      queued  <= '0;
      pending <= '0;
    end else begin
      if (ph4) begin
        wr_ptr <= wr_ptr + OUT_PTR_BITS'(1);
      end
      if (out_xfer) begin
        rd_ptr <= rd_ptr + OUT_PTR_BITS'(1);
      end
      queued  <= queued + OUT_CNT_BITS'(ph4) - OUT_CNT_BITS'(out_xfer);
      pending <= pending + OUT_CNT_BITS'(accept) - OUT_CNT_BITS'(out_xfer);
    end
  end

`ifndef ASSERT_OFF
  a_spacing : assert property (@(posedge clk) disable iff (rst) accept |=> !in_ready)
    else $error("input transfer taken in the cycle after another");
  a_mult_share : assert property (@(posedge clk) disable iff (rst) $onehot0({ph2, ph3}))
    else $error("two items on the shared multiplier");
  a_credit : assert property (@(posedge clk) disable iff (rst)
    pending <= OUT_CNT_BITS'(OUT_DEPTH) && queued <= pending)
    else $error("output credit count inconsistent");
  a_tap_vs_write : assert property (@(posedge clk) disable iff (rst)
    mem_we |-> raddr != s1_waddr)
    else $error("newer tap read from the slot being written");
  a_queue_room : assert property (@(posedge clk) disable iff (rst)
    ph4 |-> queued != OUT_CNT_BITS'(OUT_DEPTH))
    else $error("result arrived at a full output queue");
`endif

endmodule

FILE: bench/tb_top.sv
// Self-checking testbench for the fractional delay line: directed table, then random phases.
module tb_top;
  import fdl_pkg::*;

  // Cycles without a single transfer on any port before the run is declared hung.
  // The slowest legal stretch is the long output hold-off plus a few bursts of idling.
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int LONG_HOLD       = 120;
  localparam int RANDOM_PHASES   = 10;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int DRAIN_CYCLES    = 20;
  localparam int PRINT_CAP       = 30;

  // The delay register is 18 bits, Q10.8. Settings above the ceiling behave as the ceiling,
  // and settings at or below two samples pass the input straight through.
  localparam int DELAY_WIDTH = 18;
  localparam logic [DELAY_WIDTH-1:0] DELAY_CEILING  = DELAY_WIDTH'(1023 * 256);
  localparam logic [DELAY_WIDTH-1:0] BYPASS_CEILING = DELAY_WIDTH'(512);
  localparam longint SAMPLE_HIGH = 64'sd8388607;
  localparam longint SAMPLE_LOW  = -64'sd8388608;

  typedef enum logic {ROW_SAMPLE, ROW_DELAY} row_kind_t;

  // One row of the directed table: either a delay register write or a sample transfer.
  // Where the output is obvious (bypass, unwritten history, whole delays) it is typed in.
  typedef struct packed {
    row_kind_t   kind;
    logic [31:0] value;
    logic        typed;
    sample_t     want;
  } directed_row_t;

  localparam int DIRECTED_COUNT = 24;
  localparam directed_row_t DIRECTED_ROWS [0:DIRECTED_COUNT-1] = '{
    // Reset leaves the delay at zero, so the first samples pass straight through.
    '{ROW_SAMPLE, 32'h0000_0000, 1'b1, 24'h000000},
    '{ROW_SAMPLE, 32'h007F_FFFF, 1'b1, 24'h7FFFFF},
    '{ROW_SAMPLE, 32'h0080_0000, 1'b1, 24'h800000},
    '{ROW_SAMPLE, 32'h00FF_FFFF, 1'b1, 24'hFFFFFF},
    // Exactly 2.0 is still a bypass.
    '{ROW_DELAY,  32'h0000_0200, 1'b0, 24'h000000},
    '{ROW_SAMPLE, 32'h0055_5555, 1'b1, 24'h555555},
    // A whole delay of 3.0: the first three outputs read slots never written, so they are
    // zero; after that each output is the sample three transfers earlier.
    '{ROW_DELAY,  32'h0000_0300, 1'b0, 24'h000000},
    '{ROW_SAMPLE, 32'h007F_FFFF, 1'b1, 24'h000000},
    '{ROW_SAMPLE, 32'h0080_0000, 1'b1, 24'h000000},
    '{ROW_SAMPLE, 32'h00AA_AAAA, 1'b1, 24'h000000},
    '{ROW_SAMPLE, 32'h0000_0001, 1'b1, 24'h7FFFFF},
    '{ROW_SAMPLE, 32'h00FF_FFFF, 1'b1, 24'h800000},
    // Smallest delay that interpolates: 2 + 1/256.
    '{ROW_DELAY,  32'h0000_0201, 1'b0, 24'h000000},
    '{ROW_SAMPLE, 32'h0012_3456, 1'b0, 24'h000000},
    '{ROW_SAMPLE, 32'h00FE_DCBA, 1'b0, 24'h000000},
    // All ones on the bus: the register keeps 18 bits and the delay clips to the ceiling.
    '{ROW_DELAY,  32'hFFFF_FFFF, 1'b0, 24'h000000},
    '{ROW_SAMPLE, 32'h007F_FFFF, 1'b0, 24'h000000},
    // Largest fraction just under the ceiling.
    '{ROW_DELAY,  32'h0003_FEFF, 1'b0, 24'h000000},
    '{ROW_SAMPLE, 32'h0040_0000, 1'b0, 24'h000000},
    // Half-sample delay between alternating full-scale samples exercises both weights.
    '{ROW_DELAY,  32'h0000_0280, 1'b0, 24'h000000},
    '{ROW_SAMPLE, 32'h007F_FFFF, 1'b0, 24'h000000},
    '{ROW_SAMPLE, 32'h0080_0000, 1'b0, 24'h000000},
    '{ROW_SAMPLE, 32'h007F_FFFF, 1'b0, 24'h000000},
    '{ROW_SAMPLE, 32'h0080_0000, 1'b0, 24'h000000}
  };

  logic                  clk = 1'b0;
  logic                  rst;
  sample_t               sample_in;
  logic                  in_valid;
  logic                  in_ready;
  sample_t               sample_out;
  logic                  out_valid;
  logic                  out_ready;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_BITS-1:0] paddr;
  logic [DATA_BITS-1:0]  pwdata;
  logic [DATA_BITS-1:0]  prdata;
  logic                  pready;

  // Predictor state: its own copy of the sample history, the newest slot and the register.
  sample_t                echo_store [0:1023];
  logic [9:0]             newest_slot;
  logic [DELAY_WIDTH-1:0] delay_setting;

  // Outputs owed by the block, oldest first.
  sample_t owed_samples [$];

  int  mismatches     = 0;
  int  samples_sent   = 0;
  int  results_seen   = 0;
  int  bypass_items   = 0;
  int  interp_items   = 0;
  int  delay_writes   = 0;
  int  stalled_cycles = 0;
  bit  sender_idles   = 1'b1;
  bit  receiver_idles = 1'b1;
  bit  hold_request   = 1'b0;

  fractional_delay_line dut (
    .clk        (clk),
    .rst        (rst),
    .sample_in  (sample_in),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample_out (sample_out),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < PRINT_CAP)
      $display("mismatch at %0t: %s got 0x%06h, want 0x%06h", $time, what, got, want);
    mismatches++;
  endtask

  // Works out the output for one sample and advances the history the same way the block does.
  function automatic sample_t delay_line_predict(sample_t x);
    logic [DELAY_WIDTH-1:0] d;
    logic [9:0]             whole;
    int                     frac;
    longint                 near_term;
    longint                 far_term;
    longint                 sum;
    d = delay_setting;
    if (d > DELAY_CEILING)
      d = DELAY_CEILING;
    if (d <= BYPASS_CEILING) begin
      bypass_items++;
      return x;
    end
    interp_items++;
    whole = d[DELAY_WIDTH-1:8];
    frac  = int'(d[7:0]);
    // Each weighted tap is floored on its own by the arithmetic shift.
    near_term = (longint'(echo_store[newest_slot - (whole - 10'd1)]) * longint'(256 - frac)) >>> 8;
    far_term  = (longint'(echo_store[newest_slot - whole]) * longint'(frac)) >>> 8;
    sum = near_term + far_term;
    if (sum > SAMPLE_HIGH)
      sum = SAMPLE_HIGH;
    else if (sum < SAMPLE_LOW)
      sum = SAMPLE_LOW;
    newest_slot = newest_slot + 10'd1;
    echo_store[newest_slot] = x;
    return sample_t'(sum);
  endfunction

  // Mostly full-range noise, with the two rails and values near zero mixed in.
  function automatic sample_t random_sample();
    sample_t s;
    case ($urandom_range(0, 7))
      0:       s = 24'h7FFFFF;
      1:       s = 24'h800000;
      2:       s = sample_t'($urandom_range(0, 1023)) - sample_t'(512);
      default: s = sample_t'($urandom);
    endcase
    return s;
  endfunction

  // Offers one sample and holds it until the block takes it; the expectation is queued at
  // the edge of the transfer so the predictor sees samples in the block's order.
  task automatic send_sample(sample_t x, logic typed, sample_t want);
    sample_t predicted;
    @(negedge clk);
    sample_in <= x;
    in_valid  <= 1'b1;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    predicted = delay_line_predict(x);
    owed_samples.insert(owed_samples.size(), typed ? want : predicted);
    samples_sent++;
  endtask

  // Sender gap: valid drops for a random burst, then the next send raises it again.
  task automatic maybe_idle();
    if (sender_idles && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16) - 1)
        @(negedge clk);
    end
  endtask

  // Register writes only happen with the input stopped and every owed result delivered.
  task automatic wait_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (owed_samples.size() != 0)
      @(posedge clk);
  endtask

  // APB write of the delay register, followed by a read that must return the kept 18 bits.
  task automatic write_delay(logic [31:0] value);
    wait_until_drained();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_DELAY;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready)
      @(posedge clk);
    delay_setting = value[DELAY_WIDTH-1:0];
    delay_writes++;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready)
      @(posedge clk);
    if (prdata !== DATA_BITS'(delay_setting))
      report_mismatch("delay_q8 readback", prdata, DATA_BITS'(delay_setting));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Output side. It normally accepts, stalls in random bursts while receiver_idles is set,
  // and on request refuses for a long stretch so the block's output queue fills and the
  // input side backs up.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD - 1)
          @(negedge clk);
      end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16) - 1)
          @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Every output transfer is matched against the oldest owed sample.
  initial begin
    sample_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        results_seen++;
        if (owed_samples.size() == 0) begin
          report_mismatch("sample_out with nothing owed", 32'(sample_out), 32'h0);
        end else begin
          want = owed_samples.pop_front();
          if (sample_out !== want)
            report_mismatch("sample_out", 32'(sample_out), 32'(want));
        end
      end
    end
  end

  // Watchdog: any transfer on any port restarts the count.
  initial begin
    while (stalled_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pready))
        stalled_cycles = 0;
      else
        stalled_cycles++;
    end
    $display("watchdog: no transfer for %0d cycles, %0d results still owed",
             WATCHDOG_LIMIT, owed_samples.size());
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [DELAY_WIDTH-1:0] delay;
    logic [31:0]            bus_word;
    rst       = 1'b1;
    sample_in = '0;
    in_valid  = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    for (int i = 0; i < 1024; i++)
      echo_store[i] = '0;
    newest_slot   = '0;
    delay_setting = '0;
    repeat (10)
      @(negedge clk);
    rst <= 1'b0;

    // Directed table: edges of the sample range, bypass, whole and fractional delays,
    // unwritten history and the clipped ceiling.
    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      if (DIRECTED_ROWS[i].kind == ROW_DELAY) begin
        write_delay(DIRECTED_ROWS[i].value);
      end else begin
        send_sample(DIRECTED_ROWS[i].value[SAMPLE_BITS-1:0], DIRECTED_ROWS[i].typed,
                    DIRECTED_ROWS[i].want);
        maybe_idle();
      end
    end

    // Random phases, each under its own delay. Short delays dominate so that samples
    // written in a phase come back within it; the history carries over between phases.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 5))
        0:       delay = DELAY_WIDTH'($urandom_range(0, 512));
        1:       delay = DELAY_WIDTH'($urandom_range(513, 1023));
        2:       delay = DELAY_WIDTH'($urandom_range(513, 40 * 256));
        3:       delay = DELAY_WIDTH'($urandom);
        4:       delay = $urandom_range(0, 1) ? DELAY_CEILING : {DELAY_WIDTH{1'b1}};
        default: delay = DELAY_WIDTH'($urandom_range(3 * 256, 16 * 256));
      endcase
      // Bits above the register are sometimes set on the bus; they must be dropped.
      bus_word = $urandom_range(0, 1) ? ($urandom & 32'hFFFC_0000) : 32'h0;
      write_delay(bus_word | 32'(delay));
      // The final phase runs with both sides at full rate.
      sender_idles   = (phase < RANDOM_PHASES - 1);
      receiver_idles = (phase < RANDOM_PHASES - 1);
      if (phase == 3)
        hold_request = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_sample(random_sample(), 1'b0, '0);
        maybe_idle();
      end
    end

    wait_until_drained();
    repeat (DRAIN_CYCLES)
      @(posedge clk);

    $display("Covered %0d samples (%0d bypassed, %0d interpolated) under %0d delay writes.",
             samples_sent, bypass_items, interp_items, delay_writes);
    $display("Checked %0d results with one long output hold-off; %0d mismatches.",
             results_seen, mismatches);
    if (mismatches == 0 && owed_samples.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
